// ===== rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants of the box transform unit
// widths, payload structs, register indexes and pipeline control
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int Axes      = 3;
  localparam int CoordW    = 32;
  localparam int EntryW    = 16;
  localparam int MatW      = 32;
  localparam int AccW      = 64;
  localparam int FracShift = 22;
  localparam int RotW      = 48;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 48;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EntryW-1:0] entry_t;
  typedef logic signed [MatW-1:0]   mat_t;
  typedef logic signed [AccW-1:0]   acc_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_COL0     = 8'd0,
    CFG_ROT_COL1     = 8'd1,
    CFG_ROT_COL2     = 8'd2,
    CFG_SCALE_PACKED = 8'd3,
    CFG_OFFSET_X     = 8'd4,
    CFG_OFFSET_Y     = 8'd5,
    CFG_OFFSET_Z     = 8'd6
  } cfg_idx_e;

  localparam logic [RotW-1:0] RotCol0Rst = 48'h0000_0000_4000;
  localparam logic [RotW-1:0] RotCol1Rst = 48'h0000_4000_0000;
  localparam logic [RotW-1:0] RotCol2Rst = 48'h4000_0000_0000;
  localparam logic [RotW-1:0] ScaleRst   = 48'h0100_0100_0100;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } box_t;

  typedef struct packed {
    coord_t new_min_x;
    coord_t new_min_y;
    coord_t new_min_z;
    coord_t new_max_x;
    coord_t new_max_y;
    coord_t new_max_z;
  } res_t;

  // load enables of the lane stages
  typedef struct packed {
    logic en_mul;
    logic en_sel;
    logic en_part;
    logic en_sum;
  } pipe_ctrl_t;

endpackage

// ===== rtl/aat_box_if.sv =====
// ----------------------------------------------------------------------------
// aat_box_if: input box channel
// valid/ready channel carrying one axis-aligned box
// ----------------------------------------------------------------------------
interface aat_box_if import aat_pkg::*; ();
  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aat_res_if.sv =====
// ----------------------------------------------------------------------------
// aat_res_if: result box channel
// valid/ready channel carrying one transformed box
// ----------------------------------------------------------------------------
interface aat_res_if import aat_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aat_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aat_cfg_if: configuration write channel
// valid/ready channel carrying a register index and write data
// ----------------------------------------------------------------------------
interface aat_cfg_if import aat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/aat_lane.sv =====
// ----------------------------------------------------------------------------
// aat_lane: one output axis of the box transform
// matrix entries, corner products, min/max split and exact summation
// ----------------------------------------------------------------------------
module aat_lane import aat_pkg::*; (
  input  logic       clk_i,
  input  entry_t     rot_i    [Axes],
  input  entry_t     scale_i  [Axes],
  input  coord_t     offset_i,
  input  coord_t     lo_i     [Axes],
  input  coord_t     hi_i     [Axes],
  input  pipe_ctrl_t ctrl_i,
  output acc_t       sum_lo_o,
  output acc_t       sum_hi_o
);

  mat_t m_d   [Axes];
  mat_t m_q   [Axes];
  acc_t e_d   [Axes];
  acc_t f_d   [Axes];
  acc_t e_q   [Axes];
  acc_t f_q   [Axes];
  acc_t lo_t_d [Axes];
  acc_t hi_t_d [Axes];
  acc_t lo_t_q [Axes];
  acc_t hi_t_q [Axes];
  acc_t off_w;
  acc_t lo_a_q, lo_b_q, hi_a_q, hi_b_q;
  acc_t sum_lo_q, sum_hi_q;

  // scaled matrix entries follow the config registers every cycle
  always_comb begin
    for (int j = 0; j < Axes; j++) begin
      m_d[j] = mat_t'(rot_i[j]) * mat_t'(scale_i[j]);
      e_d[j] = acc_t'(m_q[j]) * acc_t'(lo_i[j]);
      f_d[j] = acc_t'(m_q[j]) * acc_t'(hi_i[j]);
      if (e_q[j] < f_q[j]) begin
        lo_t_d[j] = e_q[j];
        hi_t_d[j] = f_q[j];
      end else begin
        lo_t_d[j] = f_q[j];
        hi_t_d[j] = e_q[j];
      end
    end
  end

  // translation widened to the product scale
  assign off_w = acc_t'(offset_i) <<< FracShift;

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    if (ctrl_i.en_mul) begin
      e_q <= e_d;
      f_q <= f_d;
    end
    if (ctrl_i.en_sel) begin
      lo_t_q <= lo_t_d;
      hi_t_q <= hi_t_d;
    end
    if (ctrl_i.en_part) begin
      lo_a_q <= lo_t_q[0] + lo_t_q[1];
      lo_b_q <= lo_t_q[2] + off_w;
      hi_a_q <= hi_t_q[0] + hi_t_q[1];
      hi_b_q <= hi_t_q[2] + off_w;
    end
    if (ctrl_i.en_sum) begin
      sum_lo_q <= lo_a_q + lo_b_q;
      sum_hi_q <= hi_a_q + hi_b_q;
    end
  end

  assign sum_lo_o = sum_lo_q;
  assign sum_hi_o = sum_hi_q;

endmodule

// ===== rtl/aat_merge.sv =====
// ----------------------------------------------------------------------------
// aat_merge: result assembly
// rounds and saturates the lane sums and holds the output box
// ----------------------------------------------------------------------------
module aat_merge import aat_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  acc_t sum_lo_i [Axes],
  input  acc_t sum_hi_i [Axes],
  output res_t res_o
);

  localparam int NarrowW = AccW - FracShift;

  res_t res_d, res_q;

  // round half up, then clamp to the q16.16 range
  function automatic coord_t round_sat(input acc_t a);
    acc_t                      x;
    logic signed [NarrowW-1:0] q;
    x = a + (acc_t'(1) <<< (FracShift - 1));
    q = x[AccW-1:FracShift];
    if ((&q[NarrowW-1:CoordW-1]) || !(|q[NarrowW-1:CoordW-1])) begin
      return q[CoordW-1:0];
    end else if (q[NarrowW-1]) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  always_comb begin
    res_d.new_min_x = round_sat(sum_lo_i[0]);
    res_d.new_min_y = round_sat(sum_lo_i[1]);
    res_d.new_min_z = round_sat(sum_lo_i[2]);
    res_d.new_max_x = round_sat(sum_hi_i[0]);
    res_d.new_max_y = round_sat(sum_hi_i[1]);
    res_d.new_max_z = round_sat(sum_hi_i[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/aabb_affine_transform_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit: bounding box of a transformed axis-aligned box
// rotation, per-axis scale and translation applied to box corners, q16.16
// ----------------------------------------------------------------------------
// usage:
//   box_i   takes one box (min/max per axis, signed q16.16) per transfer
//   res_o   returns the transformed, saturated box, one per input box, in order
//   cfg_i   writes rotation columns, packed scales and offsets by index;
//           always ready; the user writes only while no box is in flight, unchecked
// timing:
//   six register stages: input, products, min/max split, partial sums,
//   full sums, rounded output; one box per cycle sustained while res_o
//   is ready; three axis lanes with six 32x32 multipliers each work in
//   parallel, the merge stage rounds and clamps
// stall:
//   each stage moves when the next one is empty or moving; while res_o is
//   held the pipeline still fills its bubbles, and box_i drops ready only
//   when every stage holds a box
// reset:
//   clears all stage valids and loads the identity transform
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit import aat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  aat_box_if.sink   box_i,
  aat_res_if.source res_o,
  aat_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [RotW-1:0] rot_col_q [Axes];
  logic [RotW-1:0] scale_q;
  coord_t          offset_q  [Axes];

  // stage valids: 1 input, 2 products, 3 split, 4 partial, 5 sum, 6 output
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  box_t       box_q;
  coord_t     lo_vec [Axes];
  coord_t     hi_vec [Axes];
  pipe_ctrl_t ctrl;
  acc_t       sum_lo [Axes];
  acc_t       sum_hi [Axes];

  // config write decode
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_col_q[0] <= RotCol0Rst;
      rot_col_q[1] <= RotCol1Rst;
      rot_col_q[2] <= RotCol2Rst;
      scale_q      <= ScaleRst;
      offset_q[0]  <= '0;
      offset_q[1]  <= '0;
      offset_q[2]  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_ROT_COL0:     rot_col_q[0] <= cfg_i.data[RotW-1:0];
        CFG_ROT_COL1:     rot_col_q[1] <= cfg_i.data[RotW-1:0];
        CFG_ROT_COL2:     rot_col_q[2] <= cfg_i.data[RotW-1:0];
        CFG_SCALE_PACKED: scale_q      <= cfg_i.data[RotW-1:0];
        CFG_OFFSET_X:     offset_q[0]  <= cfg_i.data[CoordW-1:0];
        CFG_OFFSET_Y:     offset_q[1]  <= cfg_i.data[CoordW-1:0];
        CFG_OFFSET_Z:     offset_q[2]  <= cfg_i.data[CoordW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // stage enables ripple back from the output
  assign en6 = !v6_q || res_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign box_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= box_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en1) begin
      box_q <= box_i.data;
    end
  end

  assign lo_vec[0] = box_q.box_min_x;
  assign lo_vec[1] = box_q.box_min_y;
  assign lo_vec[2] = box_q.box_min_z;
  assign hi_vec[0] = box_q.box_max_x;
  assign hi_vec[1] = box_q.box_max_y;
  assign hi_vec[2] = box_q.box_max_z;

  assign ctrl.en_mul  = en2;
  assign ctrl.en_sel  = en3;
  assign ctrl.en_part = en4;
  assign ctrl.en_sum  = en5;

  // one lane per output axis; lane i sees row i of the rotation
  for (genvar i = 0; i < Axes; i++) begin : g_lane
    entry_t rot_row [Axes];
    entry_t scale_v [Axes];

    for (genvar j = 0; j < Axes; j++) begin : g_col
      assign rot_row[j] = rot_col_q[j][EntryW*i +: EntryW];
      assign scale_v[j] = scale_q[EntryW*j +: EntryW];
    end

    aat_lane u_lane (
      .clk_i    (clk_i),
      .rot_i    (rot_row),
      .scale_i  (scale_v),
      .offset_i (offset_q[i]),
      .lo_i     (lo_vec),
      .hi_i     (hi_vec),
      .ctrl_i   (ctrl),
      .sum_lo_o (sum_lo[i]),
      .sum_hi_o (sum_hi[i])
    );
  end

  // rounding, clamping and the output register
  aat_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en6),
    .sum_lo_i (sum_lo),
    .sum_hi_i (sum_hi),
    .res_o    (res_o.data)
  );

  assign res_o.valid = v6_q;

endmodule

// ===== bench/tb_aabb_affine_transform_unit.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform_unit: self-checking bench of the box transform unit
// boxes stream through the unit under several transform settings; a local
// fixed-point model predicts every result box and the monitor compares
// each returned bound with the oldest prediction
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform_unit;
  import aat_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int ResetCycles   = 10;
  localparam int IdlePct       = 13;
  localparam int HoldCycles    = 64;   // far longer than the six pipeline stages
  localparam int DrainCycles   = 20;   // slack for the last results to leave the pipeline
  localparam int RandomPhases  = 10;
  localparam int BoxesPerPhase = 60;
  localparam int SteadyPhase   = 3;
  localparam int CycleLimit    = 200000;
  localparam int PrintCap      = 200;

  localparam logic [CfgIdxW-1:0] CfgIdxFirstUnused = 8'd7;
  localparam logic [CfgIdxW-1:0] CfgIdxLast        = 8'hff;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  // q2.14 unit for rotation entries, q8.8 range of two for moderate scales
  localparam int RotUnit   = 16384;
  localparam int ScaleSpan = 512;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  aat_box_if box_if ();
  aat_res_if res_if ();
  aat_cfg_if cfg_if ();

  aabb_affine_transform_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // boxes waiting to be offered, and transformed boxes waiting to come back
  box_t boxes_to_send [$];
  res_t bounds_due [$];

  // local copy of the transform registers, updated on every config transfer
  logic [RotW-1:0] cur_rot [Axes];
  logic [RotW-1:0] cur_scale;
  coord_t          cur_offset [Axes];

  cfg_idx_e rot_idx [Axes] = '{CFG_ROT_COL0, CFG_ROT_COL1, CFG_ROT_COL2};
  cfg_idx_e off_idx [Axes] = '{CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z};

  string res_field [2*Axes] = '{"new_min_x", "new_min_y", "new_min_z",
                                "new_max_x", "new_max_y", "new_max_z"};

  logic box_taken = 1'b0;   // box transfer seen at the last rising edge
  logic steady    = 1'b0;   // no random idling on either side while set

  // long receiver hold-offs: the stimulus asks, the ready process serves
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  int mismatch_count = 0;
  int boxes_accepted = 0;
  int results_checked = 0;
  int regs_written   = 0;
  int cycle_count    = 0;

  task automatic report_mismatch(string what);
    if (mismatch_count < PrintCap) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // sum scaled 2^-38 back to q16.16: round half up, then clamp
  function automatic coord_t to_q16_16(longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FracShift - 1))) >>> FracShift;
    if (q > longint'(CoordMax)) return CoordMax;
    if (q < longint'(CoordMin)) return CoordMin;
    return coord_t'(q);
  endfunction

  // tightest box around the transformed corners, under the current registers
  function automatic res_t transform_bounds(box_t b);
    longint lo [Axes];
    longint hi [Axes];
    longint acc_lo, acc_hi, m, e, f;
    logic signed [EntryW-1:0] rot_e, scl_e;
    coord_t new_lo [Axes];
    coord_t new_hi [Axes];
    res_t r;
    lo[0] = b.box_min_x;
    lo[1] = b.box_min_y;
    lo[2] = b.box_min_z;
    hi[0] = b.box_max_x;
    hi[1] = b.box_max_y;
    hi[2] = b.box_max_z;
    for (int i = 0; i < Axes; i++) begin
      // translation widened to the product scale
      acc_lo = longint'(cur_offset[i]) <<< FracShift;
      acc_hi = acc_lo;
      for (int j = 0; j < Axes; j++) begin
        rot_e = cur_rot[j][EntryW*i +: EntryW];
        scl_e = cur_scale[EntryW*j +: EntryW];
        m = longint'(rot_e) * longint'(scl_e);
        e = m * lo[j];
        f = m * hi[j];
        // the smaller product feeds the lower bound, works for inverted boxes
        if (e < f) begin
          acc_lo += e;
          acc_hi += f;
        end else begin
          acc_lo += f;
          acc_hi += e;
        end
      end
      new_lo[i] = to_q16_16(acc_lo);
      new_hi[i] = to_q16_16(acc_hi);
    end
    r.new_min_x = new_lo[0];
    r.new_min_y = new_lo[1];
    r.new_min_z = new_lo[2];
    r.new_max_x = new_hi[0];
    r.new_max_y = new_hi[1];
    r.new_max_z = new_hi[2];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_box(coord_t lx, coord_t ly, coord_t lz,
                                    coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.box_min_x = lx;
    b.box_min_y = ly;
    b.box_min_z = lz;
    b.box_max_x = hx;
    b.box_max_y = hy;
    b.box_max_z = hz;
    boxes_to_send.push_back(b);
  endfunction

  // coordinate mix: mostly small values, full-range noise, and values at the rails
  function automatic coord_t random_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return coord_t'($urandom_range(0, 2**21) - 2**20);
    if (pick < 85) return coord_t'($urandom);
    if (pick < 93) return CoordMax - coord_t'($urandom_range(0, 255));
    return CoordMin + coord_t'($urandom_range(0, 255));
  endfunction

  // most boxes are well formed, a few come in inverted
  function automatic void queue_random_box();
    coord_t lo [Axes];
    coord_t hi [Axes];
    coord_t t;
    bit ordered;
    ordered = $urandom_range(99) < 85;
    for (int j = 0; j < Axes; j++) begin
      lo[j] = random_coord();
      hi[j] = random_coord();
      if (ordered && lo[j] > hi[j]) begin
        t = lo[j];
        lo[j] = hi[j];
        hi[j] = t;
      end
    end
    queue_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // one 16-bit entry: within +-span, full random, or a mix of rails, zero and +-span
  function automatic logic [EntryW-1:0] random_entry(int style, int span);
    int unsigned pick;
    if (style == 0) return EntryW'($urandom_range(0, 2*span) - span);
    if (style == 1) return EntryW'($urandom);
    pick = $urandom_range(3);
    case (pick)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return EntryW'($urandom_range(0, 2*span) - span);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // configuration writes, issued only while nothing is in flight
  // --------------------------------------------------------------------------

  task automatic program_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_transform(logic [RotW-1:0] c0, logic [RotW-1:0] c1,
                                   logic [RotW-1:0] c2, logic [RotW-1:0] scl,
                                   logic [CfgDataW-1:0] ox, logic [CfgDataW-1:0] oy,
                                   logic [CfgDataW-1:0] oz);
    program_reg(CFG_ROT_COL0, c0);
    program_reg(CFG_ROT_COL1, c1);
    program_reg(CFG_ROT_COL2, c2);
    program_reg(CFG_SCALE_PACKED, scl);
    program_reg(CFG_OFFSET_X, ox);
    program_reg(CFG_OFFSET_Y, oy);
    program_reg(CFG_OFFSET_Z, oz);
  endtask

  // every register gets a fresh value; offsets carry junk above bit 31
  task automatic program_random_transform();
    logic [RotW-1:0] col;
    logic [CoordW-1:0] off;
    int style;
    style = $urandom_range(2);
    for (int j = 0; j < Axes; j++) begin
      for (int i = 0; i < Axes; i++) begin
        col[EntryW*i +: EntryW] = random_entry(style, RotUnit);
      end
      program_reg(rot_idx[j], col);
    end
    for (int j = 0; j < Axes; j++) begin
      col[EntryW*j +: EntryW] = random_entry(style, ScaleSpan);
    end
    program_reg(CFG_SCALE_PACKED, col);
    for (int i = 0; i < Axes; i++) begin
      off = (style == 0) ? CoordW'($urandom_range(0, 2**25) - 2**24) : CoordW'($urandom);
      program_reg(off_idx[i], {16'($urandom), off});
    end
    // a write to an unmapped index must leave the transform alone
    program_reg(CfgIdxW'($urandom_range(CfgIdxFirstUnused, CfgIdxLast)),
                CfgDataW'({$urandom, $urandom}));
  endtask

  // sender holds back until every offered box has come back transformed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (boxes_to_send.size() != 0 || box_if.valid || bounds_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // box driver: offers the queue head, holds it until its transfer
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!box_if.valid || box_taken) begin
        if (boxes_to_send.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          box_if.valid <= 1'b1;
          box_if.data  <= boxes_to_send.pop_front();
        end else begin
          box_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result ready: random stalls plus long hold-offs that back the pipe up
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (holds_served != holds_asked) begin
        holds_served <= holds_served + 1;
        hold_left    <= HoldCycles;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: tracks config and box transfers, checks every result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (!rst_ni) begin
      // unit comes out of reset with the identity transform
      cur_rot[0]    = RotCol0Rst;
      cur_rot[1]    = RotCol1Rst;
      cur_rot[2]    = RotCol2Rst;
      cur_scale     = ScaleRst;
      cur_offset[0] = '0;
      cur_offset[1] = '0;
      cur_offset[2] = '0;
      box_taken    <= 1'b0;
    end else begin
      box_taken <= box_if.valid && box_if.ready;

      if (cfg_if.valid && cfg_if.ready) begin
        regs_written++;
        // bits above a register's width are dropped, unmapped indexes ignored
        case (cfg_if.idx)
          CFG_ROT_COL0:     cur_rot[0]    = cfg_if.data;
          CFG_ROT_COL1:     cur_rot[1]    = cfg_if.data;
          CFG_ROT_COL2:     cur_rot[2]    = cfg_if.data;
          CFG_SCALE_PACKED: cur_scale     = cfg_if.data;
          CFG_OFFSET_X:     cur_offset[0] = cfg_if.data[CoordW-1:0];
          CFG_OFFSET_Y:     cur_offset[1] = cfg_if.data[CoordW-1:0];
          CFG_OFFSET_Z:     cur_offset[2] = cfg_if.data[CoordW-1:0];
          default: ;
        endcase
      end

      if (box_if.valid && box_if.ready) begin
        bounds_due.push_back(transform_bounds(box_if.data));
        boxes_accepted++;
      end

      if (res_if.valid && res_if.ready) begin
        if (bounds_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result box %h", res_if.data));
        end else begin
          want = bounds_due.pop_front();
          // fields are packed new_min_x first, from the top bit down
          for (int k = 0; k < 2*Axes; k++) begin
            if (res_if.data[CoordW*(2*Axes-k)-1 -: CoordW] !==
                want[CoordW*(2*Axes-k)-1 -: CoordW]) begin
              report_mismatch($sformatf("result %0d %s got %h want %h",
                              results_checked, res_field[k],
                              res_if.data[CoordW*(2*Axes-k)-1 -: CoordW],
                              want[CoordW*(2*Axes-k)-1 -: CoordW]));
            end
          end
          results_checked++;
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               bounds_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    box_if.valid = 1'b0;
    box_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.idx   = '0;
    cfg_if.data  = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity transform out of reset: zero box, plain box, rails, inverted boxes
    @(posedge clk_i);
    queue_box(0, 0, 0, 0, 0, 0);
    queue_box(-98304, 32768, -1, 131072, 65536, 0);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    queue_box(327680, 7, -1, -196608, -9, -2);
    queue_box(32'h1234_5678, -32'sd77, 1, 32'h1234_5678, -32'sd77, 1);
    queue_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin);
    wait_idle();

    // axis swap with a sign flip at half scale: odd inputs land on rounding ties
    program_transform(48'h0000_4000_0000, 48'h0000_0000_c000, 48'h4000_0000_0000,
                      48'h0080_ff80_0080, {16'h0000, 32'h0001_0000},
                      {16'h0000, 32'hffff_ffff}, {16'h0000, CoordMax});
    @(posedge clk_i);
    queue_box(1, 1, 1, 3, 3, 3);
    queue_box(-1, -3, -5, 1, 3, 5);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    queue_box(7, -7, 0, 7, -7, 0);
    wait_idle();

    // most negative rotation at the largest scale, offsets at the top rail
    program_transform(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                      48'h7fff_7fff_7fff, {16'hffff, CoordMax},
                      {16'hffff, CoordMax}, {16'hffff, CoordMax});
    program_reg(CfgIdxFirstUnused, '1);
    program_reg(CfgIdxLast, '1);
    @(posedge clk_i);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    queue_box(0, 0, 0, 0, 0, 0);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
    queue_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    wait_idle();

    // largest positive rotation at the most negative scale, offsets at the bottom
    program_transform(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
                      48'h8000_8000_8000, {16'h0000, CoordMin},
                      {16'h0000, CoordMin}, {16'h0000, CoordMin});
    @(posedge clk_i);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    queue_box(1, 1, 1, 1, 1, 1);
    queue_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    wait_idle();

    // zero matrix: the result collapses onto the translation
    program_transform('0, '0, '0, '0, {16'h0000, 32'h0000_8000}, '0,
                      {16'h0000, 32'hffff_fffe});
    @(posedge clk_i);
    queue_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    queue_random_box();
    wait_idle();

    // random transforms with random boxes; one phase without idling, two
    // phases open with a long result stall while boxes keep coming
    for (int p = 0; p < RandomPhases; p++) begin
      program_random_transform();
      @(posedge clk_i);
      steady = (p == SteadyPhase);
      if (p == 1 || p == 6) begin
        holds_asked++;
      end
      for (int n = 0; n < BoxesPerPhase; n++) begin
        queue_random_box();
      end
      wait_idle();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (bounds_due.size() != 0) begin
      report_mismatch($sformatf("%0d result boxes never arrived", bounds_due.size()));
    end

    $display("run covered %0d boxes and %0d checked results over %0d register writes",
             boxes_accepted, results_checked, regs_written);
    $display("settings: identity, swapped half scale, both rail extremes, zero matrix, %0d random",
             RandomPhases);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
